// ===== rtl/mahd_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio header decoder.
// Used by mahd_decode, mahd_divide and mpeg_audio_header_decode; depends on nothing.
package mahd_pkg;

  // Header field codes.
  localparam logic [10:0] SYNC_PATTERN   = 11'h7FF;
  localparam logic [1:0]  VCODE_MPEG1    = 2'd3;
  localparam logic [1:0]  VCODE_MPEG2    = 2'd2;
  localparam logic [1:0]  VCODE_RESERVED = 2'd1;
  localparam logic [1:0]  LCODE_RESERVED = 2'd0;
  localparam logic [3:0]  BIDX_BAD       = 4'd15;
  localparam logic [1:0]  SIDX_RESERVED  = 2'd3;
  localparam logic [1:0]  EMPH_RESERVED  = 2'd2;

  // Decoded version numbers.
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  // Decoded layer numbers.
  localparam logic [1:0] LAYER_1 = 2'd1;
  localparam logic [1:0] LAYER_2 = 2'd2;
  localparam logic [1:0] LAYER_3 = 2'd3;

  // Frame length numerators: bytes per kbps scaled by the sample rate.
  localparam logic [17:0] NUMER_LAYER1   = 18'd12000;
  localparam logic [17:0] NUMER_LSF_L3   = 18'd72000;
  localparam logic [17:0] NUMER_DEFAULT  = 18'd144000;

  // Reciprocal division: quotient = (numer * kbps * ceil(2^RECIP_SHIFT / hz)) >> RECIP_SHIFT.
  // With the product below 2^26 the error stays under 1/hz, so the quotient is exact.
  localparam int RECIP_SHIFT = 42;
  localparam int PROD_W      = 26;
  localparam int RECIP_W     = 30;
  localparam int LEN_W       = 12;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  copy_flags;
    logic [1:0]  emphasis_code;
  } hdr_fields_t;

  // Load enables for the two arithmetic stages.
  typedef struct packed {
    logic mul_load;
    logic prod_load;
  } mahd_adv_t;

  // Bitrate tables by version group and layer, LSF layers 2-3 in one; index 15 is never legal.
  localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] layer,
                                             input logic [3:0] bidx);
    logic [8:0] kbps;
    kbps = 9'd0;
    if (ver == VER_MPEG1) begin
      unique case (layer)
        LAYER_1: kbps = KBPS_V1_L1[bidx];
        LAYER_2: kbps = KBPS_V1_L2[bidx];
        LAYER_3: kbps = KBPS_V1_L3[bidx];
        default: kbps = 9'd0;
      endcase
    end else begin
      unique case (layer)
        LAYER_1:          kbps = KBPS_V2_L1[bidx];
        LAYER_2, LAYER_3: kbps = KBPS_V2_L23[bidx];
        default:          kbps = 9'd0;
      endcase
    end
    return kbps;
  endfunction

  function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] sidx);
    logic [15:0] hz;
    unique case ({ver, sidx})
      {VER_MPEG1, 2'd0}:  hz = 16'd44100;
      {VER_MPEG1, 2'd1}:  hz = 16'd48000;
      {VER_MPEG1, 2'd2}:  hz = 16'd32000;
      {VER_MPEG2, 2'd0}:  hz = 16'd22050;
      {VER_MPEG2, 2'd1}:  hz = 16'd24000;
      {VER_MPEG2, 2'd2}:  hz = 16'd16000;
      {VER_MPEG25, 2'd0}: hz = 16'd11025;
      {VER_MPEG25, 2'd1}: hz = 16'd12000;
      {VER_MPEG25, 2'd2}: hz = 16'd8000;
      default:            hz = 16'd0;
    endcase
    return hz;
  endfunction

  // ceil(2^RECIP_SHIFT / hz) for each legal sample rate.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
                                                      input logic [1:0] sidx);
    logic [RECIP_W-1:0] r;
    unique case ({ver, sidx})
      {VER_MPEG1, 2'd0}:  r = 30'd99728946;
      {VER_MPEG1, 2'd1}:  r = 30'd91625969;
      {VER_MPEG1, 2'd2}:  r = 30'd137438954;
      {VER_MPEG2, 2'd0}:  r = 30'd199457892;
      {VER_MPEG2, 2'd1}:  r = 30'd183251938;
      {VER_MPEG2, 2'd2}:  r = 30'd274877907;
      {VER_MPEG25, 2'd0}: r = 30'd398915784;
      {VER_MPEG25, 2'd1}: r = 30'd366503876;
      {VER_MPEG25, 2'd2}: r = 30'd549755814;
      default:            r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mahd_decode.sv =====
// First pipeline stage: field checks, version and layer decode, table lookups.
// Depends on mahd_pkg.
module mahd_decode (
  input  logic                          clk,
  input  logic                          load,
  input  logic [31:0]                   header_word,
  output mahd_pkg::hdr_fields_t         fields,
  output logic [17:0]                   numer,
  output logic [mahd_pkg::RECIP_W-1:0]  recip
);

  logic [1:0]            vcode;
  logic [1:0]            lcode;
  logic [3:0]            bidx;
  logic [1:0]            sidx;
  logic                  legal;
  logic [1:0]            ver;
  logic [1:0]            layer;
  mahd_pkg::hdr_fields_t dec;
  logic [17:0]           numer_sel;

  assign vcode = header_word[20:19];
  assign lcode = header_word[18:17];
  assign bidx  = header_word[15:12];
  assign sidx  = header_word[11:10];

  assign legal = (header_word[31:21] == mahd_pkg::SYNC_PATTERN)
              && (vcode != mahd_pkg::VCODE_RESERVED)
              && (lcode != mahd_pkg::LCODE_RESERVED)
              && (bidx != mahd_pkg::BIDX_BAD)
              && (sidx != mahd_pkg::SIDX_RESERVED)
              && (header_word[1:0] != mahd_pkg::EMPH_RESERVED);

  always_comb begin
    unique case (vcode)
      mahd_pkg::VCODE_MPEG1: ver = mahd_pkg::VER_MPEG1;
      mahd_pkg::VCODE_MPEG2: ver = mahd_pkg::VER_MPEG2;
      default:               ver = mahd_pkg::VER_MPEG25;
    endcase
  end

  // Layer code 3, 2, 1 stands for layer 1, 2, 3.
  assign layer = 2'(2'd0 - lcode);

  always_comb begin
    dec = '0;
    if (legal) begin
      dec.valid_res      = 1'b1;
      dec.mpeg_version   = ver;
      dec.layer_number   = layer;
      dec.crc_protected  = ~header_word[16];
      dec.bitrate_kbps   = mahd_pkg::kbps_lookup(ver, layer, bidx);
      dec.sample_rate_hz = mahd_pkg::hz_lookup(ver, sidx);
      dec.padding_bit    = header_word[9];
      dec.channel_mode   = header_word[7:6];
      dec.mode_extension = header_word[5:4];
      dec.copy_flags     = header_word[3:2];
      dec.emphasis_code  = header_word[1:0];
    end
  end

  always_comb begin
    if (layer == mahd_pkg::LAYER_1) begin
      numer_sel = mahd_pkg::NUMER_LAYER1;
    end else if (layer == mahd_pkg::LAYER_3 && ver != mahd_pkg::VER_MPEG1) begin
      numer_sel = mahd_pkg::NUMER_LSF_L3;
    end else begin
      numer_sel = mahd_pkg::NUMER_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fields <= dec;
      numer  <= numer_sel;
      recip  <= mahd_pkg::recip_lookup(ver, sidx);
    end
  end

endmodule

// ===== rtl/mahd_divide.sv =====
// Second and third pipeline stages: numerator times bitrate, then times the
// reciprocal of the sample rate. Depends on mahd_pkg.
module mahd_divide (
  input  logic                          clk,
  input  mahd_pkg::mahd_adv_t           adv,
  input  mahd_pkg::hdr_fields_t         fields_in,
  input  logic [17:0]                   numer,
  input  logic [mahd_pkg::RECIP_W-1:0]  recip,
  output mahd_pkg::hdr_fields_t         fields_out,
  output logic [mahd_pkg::LEN_W-1:0]    quotient
);

  localparam int FULL_W = mahd_pkg::PROD_W + mahd_pkg::RECIP_W;

  mahd_pkg::hdr_fields_t          fields_mul;
  logic [mahd_pkg::PROD_W-1:0]    prod;
  logic [mahd_pkg::RECIP_W-1:0]   recip_mul;
  logic [26:0]                    prod_wide;
  logic [FULL_W-1:0]              full;

  // Widest numerator times widest bitrate stays below 2^26.
  assign prod_wide = numer * fields_in.bitrate_kbps;
  assign full      = prod * recip_mul;

  always_ff @(posedge clk) begin
    if (adv.mul_load) begin
      fields_mul <= fields_in;
      prod       <= prod_wide[mahd_pkg::PROD_W-1:0];
      recip_mul  <= recip;
    end
    if (adv.prod_load) begin
      fields_out <= fields_mul;
      quotient   <= full[mahd_pkg::RECIP_SHIFT +: mahd_pkg::LEN_W];
    end
  end

endmodule

// ===== rtl/mpeg_audio_header_decode.sv =====
// MPEG audio frame header decoder, four-stage pipeline with valid/ready channels.
// Depends on mahd_pkg, mahd_decode and mahd_divide.

// Each input word is one 32-bit frame header, first stream byte in bits 31 to 24.
// The block checks the sync, rejects reserved or illegal codes, and returns the
// decoded version, layer, bitrate, sample rate, flags and the frame length in
// bytes; an invalid header yields valid_res low and all other fields zero, and a
// free-bitrate header yields zero bitrate and length. The pipeline is four
// register stages deep (decode and lookup, bitrate multiply, reciprocal multiply,
// length and output register). The first stage loads at the edge that accepts a
// word, and the result moves on through the two multiply stages to the output
// register. A new word can be taken every cycle while the output is not stalled,
// so one word per cycle is sustained; the clock period is bounded by the
// reciprocal multiply stage, a 26 by 30 bit product, which is the deepest logic
// between registers. Each stage holds its word while the stage after it is
// full and stalled, and empty stages fill even while the output waits.
module mpeg_audio_header_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [1:0]  mpeg_version,
  output logic [1:0]  layer_number,
  output logic        crc_protected,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic        padding_bit,
  output logic [1:0]  channel_mode,
  output logic [1:0]  mode_extension,
  output logic [1:0]  copy_flags,
  output logic [1:0]  emphasis_code,
  output logic [11:0] frame_bytes
);

  // Valid bits of the four stages; stage 4 is the output register.
  logic v1, v2, v3;
  logic r1, r2, r3, r4;

  mahd_pkg::hdr_fields_t          fields_dec;
  mahd_pkg::hdr_fields_t          fields_div;
  mahd_pkg::hdr_fields_t          fields_res;
  logic [17:0]                    numer;
  logic [mahd_pkg::RECIP_W-1:0]   recip;
  logic [mahd_pkg::LEN_W-1:0]     quotient;
  logic [mahd_pkg::LEN_W-1:0]     len_next;
  logic [mahd_pkg::LEN_W-1:0]     frame_len;
  mahd_pkg::mahd_adv_t            adv;

  // A stage can take a word when it is empty or its word moves on this cycle.
  assign r4 = ~out_valid | out_ready;
  assign r3 = ~v3 | r4;
  assign r2 = ~v2 | r3;
  assign r1 = ~v1 | r2;
  assign in_ready = r1;

  assign adv.mul_load  = r2 & v1;
  assign adv.prod_load = r3 & v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        out_valid <= v3;
      end
    end
  end

  mahd_decode u_decode (
    .clk         (clk),
    .load        (r1 & in_valid),
    .header_word (header_word),
    .fields      (fields_dec),
    .numer       (numer),
    .recip       (recip)
  );

  mahd_divide u_divide (
    .clk        (clk),
    .adv        (adv),
    .fields_in  (fields_dec),
    .numer      (numer),
    .recip      (recip),
    .fields_out (fields_div),
    .quotient   (quotient)
  );

  // Layer I counts four-byte slots, so padding is added before scaling by four.
  // Free bitrate and invalid headers both carry a zero bitrate, hence zero length.
  always_comb begin
    if (fields_div.bitrate_kbps == '0) begin
      len_next = '0;
    end else if (fields_div.layer_number == mahd_pkg::LAYER_1) begin
      len_next = {quotient[mahd_pkg::LEN_W-3:0] + {9'd0, fields_div.padding_bit}, 2'b00};
    end else begin
      len_next = quotient + {11'd0, fields_div.padding_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (r4 & v3) begin
      fields_res <= fields_div;
      frame_len  <= len_next;
    end
  end

  assign valid_res      = fields_res.valid_res;
  assign mpeg_version   = fields_res.mpeg_version;
  assign layer_number   = fields_res.layer_number;
  assign crc_protected  = fields_res.crc_protected;
  assign bitrate_kbps   = fields_res.bitrate_kbps;
  assign sample_rate_hz = fields_res.sample_rate_hz;
  assign padding_bit    = fields_res.padding_bit;
  assign channel_mode   = fields_res.channel_mode;
  assign mode_extension = fields_res.mode_extension;
  assign copy_flags     = fields_res.copy_flags;
  assign emphasis_code  = fields_res.emphasis_code;
  assign frame_bytes    = frame_len;

endmodule

// ===== dv/tb_mpeg_audio_header_decode.sv =====
// Self-checking testbench for the MPEG audio frame header decoder.
// Depends on mahd_pkg for the header codes and on the mpeg_audio_header_decode RTL.
`timescale 1ns / 1ps

module tb_mpeg_audio_header_decode;

  // Header codes that the package leaves unnamed.
  localparam logic [1:0] VCODE_MPEG25 = 2'd0;
  localparam logic [1:0] LCODE_L1     = 2'd3;
  localparam logic [1:0] LCODE_L2     = 2'd2;
  localparam logic [1:0] LCODE_L3     = 2'd1;
  localparam logic [1:0] MODE_STEREO  = 2'd0;
  localparam logic [1:0] MODE_JOINT   = 2'd1;
  localparam logic [1:0] MODE_DUAL    = 2'd2;
  localparam logic [1:0] MODE_MONO    = 2'd3;
  localparam logic [1:0] EMPH_NONE    = 2'd0;
  localparam logic [1:0] EMPH_5015    = 2'd1;
  localparam logic [1:0] EMPH_CCITT   = 2'd3;

  // Bytes per frame per kbps, scaled by the sample rate.
  localparam int SCALE_LAYER1  = 12000;
  localparam int SCALE_LSF_L3  = 72000;
  localparam int SCALE_DEFAULT = 144000;

  // Bitrate rows in kbps, indexed by the bitrate index 0 to 14.
  localparam int RATE_V1_L1 [15] = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352,
                                     384, 416, 448};
  localparam int RATE_V1_L2 [15] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                     256, 320, 384};
  localparam int RATE_V1_L3 [15] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                     224, 256, 320};
  localparam int RATE_V2_L1 [15] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176,
                                     192, 224, 256};
  localparam int RATE_V2_LX [15] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                     128, 144, 160};
  // MPEG-1 rates; MPEG-2 halves them and MPEG-2.5 quarters them.
  localparam int BASE_HZ [3] = '{44100, 48000, 32000};

  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WORDS_PER_PHASE = 350;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  copy_flags;
    logic [1:0]  emphasis_code;
    logic [11:0] frame_bytes;
  } hdr_result_t;

  // One row of the directed table. When has_literal is set the row carries its
  // own typed-in result; otherwise the decoder model below supplies it.
  typedef struct {
    logic [31:0] word;
    bit          has_literal;
    hdr_result_t literal;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] header_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        valid_res;
  logic [1:0]  mpeg_version;
  logic [1:0]  layer_number;
  logic        crc_protected;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic        padding_bit;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [1:0]  copy_flags;
  logic [1:0]  emphasis_code;
  logic [11:0] frame_bytes;

  // Decoded headers still owed by the block, oldest first.
  hdr_result_t pending_decodes[$];
  stim_row_t   directed_rows[$];

  int err_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  mpeg_audio_header_decode uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .header_word    (header_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valid_res      (valid_res),
    .mpeg_version   (mpeg_version),
    .layer_number   (layer_number),
    .crc_protected  (crc_protected),
    .bitrate_kbps   (bitrate_kbps),
    .sample_rate_hz (sample_rate_hz),
    .padding_bit    (padding_bit),
    .channel_mode   (channel_mode),
    .mode_extension (mode_extension),
    .copy_flags     (copy_flags),
    .emphasis_code  (emphasis_code),
    .frame_bytes    (frame_bytes)
  );

  // 8 ns clock, high and low for 4 ns each.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Assembles a header word from its fields, with a good sync in front.
  function automatic logic [31:0] mk_hdr(input logic [1:0] vcode, input logic [1:0] lcode,
                                         input logic prot, input logic [3:0] bidx,
                                         input logic [1:0] sidx, input logic pad,
                                         input logic priv, input logic [1:0] mode,
                                         input logic [1:0] ext, input logic [1:0] cpy,
                                         input logic [1:0] emph);
    return {mahd_pkg::SYNC_PATTERN, vcode, lcode, prot, bidx, sidx, pad, priv, mode, ext,
            cpy, emph};
  endfunction

  function automatic int kbps_of(input logic [1:0] ver, input logic [1:0] layer,
                                 input logic [3:0] bidx);
    if (ver == mahd_pkg::VER_MPEG1) begin
      case (layer)
        mahd_pkg::LAYER_1: return RATE_V1_L1[bidx];
        mahd_pkg::LAYER_2: return RATE_V1_L2[bidx];
        default:           return RATE_V1_L3[bidx];
      endcase
    end
    return (layer == mahd_pkg::LAYER_1) ? RATE_V2_L1[bidx] : RATE_V2_LX[bidx];
  endfunction

  // Decoder model: what the block must return for one header word.
  function automatic hdr_result_t decode_header(input logic [31:0] w);
    hdr_result_t r;
    logic [1:0]  ver;
    logic [1:0]  layer;
    int          kbps;
    int          hz;
    int          len;
    r = '0;
    if (w[31:21] != mahd_pkg::SYNC_PATTERN) return r;
    if (w[20:19] == mahd_pkg::VCODE_RESERVED || w[18:17] == mahd_pkg::LCODE_RESERVED ||
        w[15:12] == mahd_pkg::BIDX_BAD || w[11:10] == mahd_pkg::SIDX_RESERVED ||
        w[1:0] == mahd_pkg::EMPH_RESERVED)
      return r;
    case (w[20:19])
      mahd_pkg::VCODE_MPEG1: ver = mahd_pkg::VER_MPEG1;
      mahd_pkg::VCODE_MPEG2: ver = mahd_pkg::VER_MPEG2;
      default:               ver = mahd_pkg::VER_MPEG25;
    endcase
    case (w[18:17])
      LCODE_L1: layer = mahd_pkg::LAYER_1;
      LCODE_L2: layer = mahd_pkg::LAYER_2;
      default:  layer = mahd_pkg::LAYER_3;
    endcase
    kbps = kbps_of(ver, layer, w[15:12]);
    hz = BASE_HZ[w[11:10]] >> ver;
    if (kbps == 0)
      len = 0;
    else if (layer == mahd_pkg::LAYER_1)
      len = (SCALE_LAYER1 * kbps / hz + w[9]) * 4;
    else if (layer == mahd_pkg::LAYER_3 && ver != mahd_pkg::VER_MPEG1)
      len = SCALE_LSF_L3 * kbps / hz + w[9];
    else
      len = SCALE_DEFAULT * kbps / hz + w[9];
    r.valid_res      = 1'b1;
    r.mpeg_version   = ver;
    r.layer_number   = layer;
    r.crc_protected  = ~w[16];
    r.bitrate_kbps   = 9'(kbps);
    r.sample_rate_hz = 16'(hz);
    r.padding_bit    = w[9];
    r.channel_mode   = w[7:6];
    r.mode_extension = w[5:4];
    r.copy_flags     = w[3:2];
    r.emphasis_code  = w[1:0];
    r.frame_bytes    = 12'(len);
    return r;
  endfunction

  // Random header: mostly legal headers with random content, a few with reserved
  // fields or a damaged sync, and some raw 32-bit noise.
  function automatic logic [31:0] gen_header_word();
    logic [1:0]  vcode;
    logic [1:0]  lcode;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    logic [1:0]  emph;
    logic [31:0] w;
    if ($urandom_range(99) < 15) return $urandom();
    case ($urandom_range(2))
      0:       vcode = mahd_pkg::VCODE_MPEG1;
      1:       vcode = mahd_pkg::VCODE_MPEG2;
      default: vcode = VCODE_MPEG25;
    endcase
    if ($urandom_range(99) < 4) vcode = mahd_pkg::VCODE_RESERVED;
    lcode = ($urandom_range(99) < 4) ? mahd_pkg::LCODE_RESERVED : 2'($urandom_range(1, 3));
    bidx = ($urandom_range(99) < 4) ? mahd_pkg::BIDX_BAD : 4'($urandom_range(14));
    sidx = ($urandom_range(99) < 4) ? mahd_pkg::SIDX_RESERVED : 2'($urandom_range(2));
    case ($urandom_range(2))
      0:       emph = EMPH_NONE;
      1:       emph = EMPH_5015;
      default: emph = EMPH_CCITT;
    endcase
    if ($urandom_range(99) < 4) emph = mahd_pkg::EMPH_RESERVED;
    w = mk_hdr(vcode, lcode, 1'($urandom()), bidx, sidx, 1'($urandom()), 1'($urandom()),
               2'($urandom()), 2'($urandom()), 2'($urandom()), emph);
    if ($urandom_range(99) < 3) w = w ^ (32'h1 << (21 + $urandom_range(10)));
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offers one header word, with random idle cycles in front of it, and holds
  // it until the block takes it. The decode it must produce is queued at the
  // edge that accepts the word.
  task automatic send_word(input logic [31:0] w, input hdr_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    header_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_decodes.push_back(want);
  endtask

  // Receiver: random stalls at the current rate, and a long hold-off whenever
  // the stimulus asks for one, so that the pipeline fills and backs up.
  always @(negedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every result word taken from the block is checked against the oldest
  // outstanding decode, one field at a time.
  always @(posedge clk) begin : result_check
    hdr_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result word with no header word outstanding");
      end else begin
        want = pending_decodes.pop_front();
        check_field("valid_res", valid_res, want.valid_res);
        check_field("mpeg_version", mpeg_version, want.mpeg_version);
        check_field("layer_number", layer_number, want.layer_number);
        check_field("crc_protected", crc_protected, want.crc_protected);
        check_field("bitrate_kbps", bitrate_kbps, want.bitrate_kbps);
        check_field("sample_rate_hz", sample_rate_hz, want.sample_rate_hz);
        check_field("padding_bit", padding_bit, want.padding_bit);
        check_field("channel_mode", channel_mode, want.channel_mode);
        check_field("mode_extension", mode_extension, want.mode_extension);
        check_field("copy_flags", copy_flags, want.copy_flags);
        check_field("emphasis_code", emphasis_code, want.emphasis_code);
        check_field("frame_bytes", frame_bytes, want.frame_bytes);
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_mpeg_audio_header_decode NOT OK");
        $finish;
      end
    end
  end

  initial begin
    // Directed table. Invalid headers must come back all zero, and the longest
    // frame length, an MPEG-1 layer I header and a free-bitrate header are typed
    // in directly; the remaining rows go through the decoder model, and with the
    // typed-in rows every version and layer pairing is covered.
    directed_rows.push_back('{32'h0000_0000, 1'b1, '0});
    directed_rows.push_back('{32'hFFFF_FFFF, 1'b1, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L1, 1'b0, 4'd14, 2'd2, 1'b1,
                              1'b1, MODE_MONO, 2'd3, 2'b11, EMPH_CCITT), 1'b1,
                              hdr_result_t'{1'b1, mahd_pkg::VER_MPEG1, mahd_pkg::LAYER_1,
                              1'b1, 9'd448, 16'd32000, 1'b1, MODE_MONO, 2'd3, 2'b11,
                              EMPH_CCITT, 12'd676}});
    directed_rows.push_back('{mk_hdr(VCODE_MPEG25, LCODE_L2, 1'b1, 4'd14, 2'd2, 1'b1, 1'b0,
                              MODE_STEREO, 2'd0, 2'b00, EMPH_NONE), 1'b1,
                              hdr_result_t'{1'b1, mahd_pkg::VER_MPEG25, mahd_pkg::LAYER_2,
                              1'b0, 9'd160, 16'd8000, 1'b1, MODE_STEREO, 2'd0, 2'b00,
                              EMPH_NONE, 12'd2881}});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L3, 1'b1, 4'd0, 2'd0, 1'b0,
                              1'b0, MODE_JOINT, 2'd2, 2'b01, EMPH_5015), 1'b1,
                              hdr_result_t'{1'b1, mahd_pkg::VER_MPEG1, mahd_pkg::LAYER_3,
                              1'b0, 9'd0, 16'd44100, 1'b0, MODE_JOINT, 2'd2, 2'b01,
                              EMPH_5015, 12'd0}});
    // Sync broken at its lowest and at its highest bit.
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L2, 1'b1, 4'd9, 2'd1, 1'b0,
                              1'b0, MODE_STEREO, 2'd0, 2'b00, EMPH_NONE) ^ 32'h0020_0000,
                              1'b1, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L2, 1'b1, 4'd9, 2'd1, 1'b0,
                              1'b0, MODE_STEREO, 2'd0, 2'b00, EMPH_NONE) ^ 32'h8000_0000,
                              1'b1, '0});
    // Each reserved or illegal field on its own.
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_RESERVED, LCODE_L3, 1'b1, 4'd9, 2'd0,
                              1'b0, 1'b0, MODE_STEREO, 2'd0, 2'b00, EMPH_NONE), 1'b1, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, mahd_pkg::LCODE_RESERVED, 1'b1,
                              4'd9, 2'd0, 1'b0, 1'b0, MODE_STEREO, 2'd0, 2'b00, EMPH_NONE),
                              1'b1, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG2, LCODE_L3, 1'b1, mahd_pkg::BIDX_BAD,
                              2'd0, 1'b0, 1'b0, MODE_STEREO, 2'd0, 2'b00, EMPH_NONE), 1'b1,
                              '0});
    directed_rows.push_back('{mk_hdr(VCODE_MPEG25, LCODE_L1, 1'b1, 4'd3,
                              mahd_pkg::SIDX_RESERVED, 1'b0, 1'b0, MODE_STEREO, 2'd0, 2'b00,
                              EMPH_NONE), 1'b1, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L3, 1'b1, 4'd9, 2'd0, 1'b0,
                              1'b0, MODE_STEREO, 2'd0, 2'b00, mahd_pkg::EMPH_RESERVED), 1'b1,
                              '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L2, 1'b0, 4'd14, 2'd1, 1'b0,
                              1'b0, MODE_DUAL, 2'd1, 2'b10, EMPH_NONE), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG1, LCODE_L3, 1'b1, 4'd1, 2'd0, 1'b1,
                              1'b0, MODE_JOINT, 2'd3, 2'b01, EMPH_5015), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG2, LCODE_L1, 1'b0, 4'd14, 2'd0, 1'b1,
                              1'b1, MODE_MONO, 2'd0, 2'b11, EMPH_CCITT), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG2, LCODE_L2, 1'b1, 4'd5, 2'd1, 1'b0,
                              1'b0, MODE_STEREO, 2'd2, 2'b00, EMPH_NONE), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG2, LCODE_L3, 1'b1, 4'd1, 2'd1, 1'b1,
                              1'b0, MODE_JOINT, 2'd1, 2'b01, EMPH_NONE), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(mahd_pkg::VCODE_MPEG2, LCODE_L3, 1'b0, 4'd14, 2'd2, 1'b1,
                              1'b1, MODE_DUAL, 2'd0, 2'b10, EMPH_CCITT), 1'b0, '0});
    // MPEG-2.5 at rate index 1 must report 12000 Hz.
    directed_rows.push_back('{mk_hdr(VCODE_MPEG25, LCODE_L1, 1'b1, 4'd9, 2'd1, 1'b0, 1'b0,
                              MODE_MONO, 2'd0, 2'b00, EMPH_5015), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(VCODE_MPEG25, LCODE_L3, 1'b0, 4'd14, 2'd1, 1'b1, 1'b1,
                              MODE_JOINT, 2'd2, 2'b11, EMPH_NONE), 1'b0, '0});
    directed_rows.push_back('{mk_hdr(VCODE_MPEG25, LCODE_L3, 1'b1, 4'd7, 2'd0, 1'b0, 1'b1,
                              MODE_STEREO, 2'd3, 2'b01, EMPH_CCITT), 1'b0, '0});

    // Reset is held and then released on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].has_literal ?
                directed_rows[i].literal : decode_header(directed_rows[i].word));

    // Random phases: no idling, sender idle, receiver stalling, then both.
    // The first and last phases open with a long receiver hold-off while the
    // sender keeps offering words, back to back in the first phase.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (phase == 0 || phase == 3) holds_requested++;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        logic [31:0] w;
        w = gen_header_word();
        send_word(w, decode_header(w));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    // A few more cycles so that any stray result word would be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_mpeg_audio_header_decode OK");
    else
      $display("tb_mpeg_audio_header_decode NOT OK");
    $finish;
  end

endmodule

// ===== mpeg_audio_header_decode.f =====
rtl/mahd_pkg.sv
rtl/mahd_decode.sv
rtl/mahd_divide.sv
rtl/mpeg_audio_header_decode.sv
dv/tb_mpeg_audio_header_decode.sv
